### rtl/core/b64sc_pkg.sv
// Shared constants, codes and character tables for the base64 stream codec.
// No dependencies; used by base64_stream_codec.
`default_nettype none

package b64sc_pkg;

  // Direction register values.
  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // Error codes carried on the result tuser.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_LEN  = 2'd2;

  // Decoded character classes beyond the 64 alphabet values.
  localparam logic [6:0] CODE_PAD = 7'd64;
  localparam logic [6:0] CODE_BAD = 7'd65;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Maximum number of results one input transaction can cause.
  localparam int unsigned MaxResults = 4;

  // Six-bit value to its alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] six);
    logic [7:0] s;
    s = {2'b00, six};
    if (six < 6'd26) begin
      enc_char = s + 8'h41;
    end else if (six < 6'd52) begin
      enc_char = s + 8'h47;
    end else if (six < 6'd62) begin
      enc_char = s - 8'd4;
    end else if (six == 6'd62) begin
      enc_char = 8'h2B;
    end else begin
      enc_char = 8'h2F;
    end
  endfunction

  // Character to its six-bit value, or the pad or bad class.
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      dec_char = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      dec_char = 7'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      dec_char = 7'(c + 8'd4);
    end else if (c == 8'h2B) begin
      dec_char = 7'd62;
    end else if (c == 8'h2F) begin
      dec_char = 7'd63;
    end else if (c == PAD_CHAR) begin
      dec_char = CODE_PAD;
    end else begin
      dec_char = CODE_BAD;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/base64_stream_codec.sv
// Base64 stream codec (standard alphabet, '=' padding), encode or decode.
// Depends on b64sc_pkg for character tables and codes.
//
//   channel   | direction | width             | notes
//   ----------+-----------+-------------------+------------------------------
//   s_axis    | in        | tdata 8, tlast 1  | byte (encode) or char (decode)
//   m_axis    | out       | tdata 8, tlast 1, | char or byte; tuser = error
//             |           | tuser 2           |
//   cfg       | in        | data 1            | direction; resets stream state
//
// Each input transaction is decoded combinationally into a burst register of up
// to four results, which drains one result per cycle on m_axis while m_axis_tready
// is high. An item gives at most one result per decode character, up to three
// on a bad or final character, four per three encoded bytes and up to four on
// the last byte. A new item is taken in the same cycle the last result of the
// burst is taken. Stalls on m_axis hold the burst and back-pressure s_axis.
// Reset clears direction to encode and empties all stream state.
`default_nettype none

module base64_stream_codec (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration: direction register.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  // Input stream.
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_value
  input  wire logic       s_axis_tlast,   // in_last
  // Result stream.
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_value
  output logic            m_axis_tlast,   // out_last
  output logic [1:0]      m_axis_tuser    // [1:0] error_code
);

  localparam int unsigned NRes = b64sc_pkg::MaxResults;

  // Stream state.
  logic       dir_q;
  logic [1:0] phase_q, phase_d;
  logic [5:0] resid_q, resid_d;
  logic [1:0] pad_q, pad_d;
  logic [7:0] pend_q, pend_d;
  logic       pend_vld_q, pend_vld_d;

  // Burst of pending results; entry 0 is presented on m_axis.
  logic [7:0] buf_val_q  [NRes];
  logic       buf_last_q [NRes];
  logic [1:0] buf_err_q  [NRes];
  logic [2:0] cnt_q;

  // Results of the current input item.
  logic [7:0] res_val  [NRes];
  logic       res_last [NRes];
  logic [1:0] res_err  [NRes];
  logic [2:0] res_n;

  logic       in_acc, out_acc, cfg_acc;
  logic [7:0] v;
  logic [6:0] code;
  logic       bad;
  logic [1:0] ph_next;
  logic [7:0] byte_v;
  logic       have;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (cnt_q == 3'd0) | ((cnt_q == 3'd1) & m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign m_axis_tdata = buf_val_q[0];
  assign m_axis_tlast = buf_last_q[0];
  assign m_axis_tuser = buf_err_q[0];

  assign v    = s_axis_tdata;
  assign code = b64sc_pkg::dec_char(v);

  always_comb begin
    for (int i = 0; i < NRes; i++) begin
      res_val[i]  = '0;
      res_last[i] = 1'b0;
      res_err[i]  = b64sc_pkg::ERR_NONE;
    end
    res_n      = '0;
    phase_d    = phase_q;
    resid_d    = resid_q;
    pad_d      = pad_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    bad        = 1'b0;
    have       = 1'b0;
    byte_v     = '0;
    ph_next    = phase_q + 2'd1;

    if (dir_q == b64sc_pkg::DIR_ENC) begin
      case (phase_q)
        2'd0: begin
          res_val[0] = b64sc_pkg::enc_char(v[7:2]);
          resid_d    = {v[1:0], 4'b0000};
          phase_d    = 2'd1;
          if (s_axis_tlast) begin
            res_val[1]  = b64sc_pkg::enc_char({v[1:0], 4'b0000});
            res_val[2]  = b64sc_pkg::PAD_CHAR;
            res_val[3]  = b64sc_pkg::PAD_CHAR;
            res_last[3] = 1'b1;
            res_n       = 3'd4;
          end else begin
            res_n = 3'd1;
          end
        end
        2'd1: begin
          res_val[0] = b64sc_pkg::enc_char(resid_q | {2'b00, v[7:4]});
          resid_d    = {v[3:0], 2'b00};
          phase_d    = 2'd2;
          if (s_axis_tlast) begin
            res_val[1]  = b64sc_pkg::enc_char({v[3:0], 2'b00});
            res_val[2]  = b64sc_pkg::PAD_CHAR;
            res_last[2] = 1'b1;
            res_n       = 3'd3;
          end else begin
            res_n = 3'd1;
          end
        end
        default: begin
          res_val[0]  = b64sc_pkg::enc_char(resid_q | {4'b0000, v[7:6]});
          res_val[1]  = b64sc_pkg::enc_char(v[5:0]);
          res_last[1] = s_axis_tlast;
          resid_d     = '0;
          phase_d     = 2'd0;
          res_n       = 3'd2;
        end
      endcase
      if (s_axis_tlast) begin
        phase_d    = '0;
        resid_d    = '0;
        pad_d      = '0;
        pend_d     = '0;
        pend_vld_d = 1'b0;
      end
    end else begin
      bad = (code == b64sc_pkg::CODE_BAD)
          | ((code == b64sc_pkg::CODE_PAD) & (phase_q < 2'd2))
          | ((code != b64sc_pkg::CODE_PAD) & (pad_q != 2'd0));
      if (bad) begin
        if (pend_vld_q) begin
          res_val[0] = pend_q;
          res_n      = 3'd1;
        end
        res_last[res_n[1:0]] = 1'b1;
        res_err[res_n[1:0]]  = b64sc_pkg::ERR_CHAR;
        res_n                = res_n + 3'd1;
        phase_d    = '0;
        resid_d    = '0;
        pad_d      = '0;
        pend_d     = '0;
        pend_vld_d = 1'b0;
      end else begin
        if (code == b64sc_pkg::CODE_PAD) begin
          if (pad_q < 2'd2) begin
            pad_d = pad_q + 2'd1;
          end
        end else begin
          case (phase_q)
            2'd0: begin
              resid_d = code[5:0];
            end
            2'd1: begin
              byte_v  = {resid_q, code[5:4]};
              resid_d = {2'b00, code[3:0]};
              have    = 1'b1;
            end
            2'd2: begin
              byte_v  = {resid_q[3:0], code[5:2]};
              resid_d = {4'b0000, code[1:0]};
              have    = 1'b1;
            end
            default: begin
              byte_v  = {resid_q[1:0], code[5:0]};
              resid_d = '0;
              have    = 1'b1;
            end
          endcase
        end
        if (have) begin
          if (pend_vld_q) begin
            res_val[0] = pend_q;
            res_n      = 3'd1;
          end
          pend_d     = byte_v;
          pend_vld_d = 1'b1;
        end
        phase_d = ph_next;
        if (s_axis_tlast) begin
          // The held byte goes out with the end of the stream or ahead of
          // the short-length error.
          if (ph_next != 2'd0) begin
            if (pend_vld_d) begin
              res_val[res_n[1:0]] = pend_d;
              res_n               = res_n + 3'd1;
            end
            res_last[res_n[1:0]] = 1'b1;
            res_err[res_n[1:0]]  = b64sc_pkg::ERR_LEN;
            res_n                = res_n + 3'd1;
          end else if (pend_vld_d) begin
            res_val[res_n[1:0]]  = pend_d;
            res_last[res_n[1:0]] = 1'b1;
            res_n                = res_n + 3'd1;
          end
          phase_d    = '0;
          resid_d    = '0;
          pad_d      = '0;
          pend_d     = '0;
          pend_vld_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= b64sc_pkg::DIR_ENC;
      phase_q    <= '0;
      resid_q    <= '0;
      pad_q      <= '0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cfg_acc) begin
        dir_q      <= cfg_data_i;
        phase_q    <= '0;
        resid_q    <= '0;
        pad_q      <= '0;
        pend_vld_q <= 1'b0;
      end else if (in_acc) begin
        phase_q    <= phase_d;
        resid_q    <= resid_d;
        pad_q      <= pad_d;
        pend_vld_q <= pend_vld_d;
      end
      if (in_acc) begin
        cnt_q <= res_n;
      end else if (out_acc) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  // Payload registers: the held byte and the result burst.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= pend_d;
      for (int i = 0; i < NRes; i++) begin
        buf_val_q[i]  <= res_val[i];
        buf_last_q[i] <= res_last[i];
        buf_err_q[i]  <= res_err[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < NRes - 1; i++) begin
        buf_val_q[i]  <= buf_val_q[i+1];
        buf_last_q[i] <= buf_last_q[i+1];
        buf_err_q[i]  <= buf_err_q[i+1];
      end
    end
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result burst count out of range");

  a_last_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q > 3'd1 |-> !buf_last_q[0])
    else $error("end-of-stream marker ahead of other results");

  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (buf_err_q[0] != b64sc_pkg::ERR_NONE) |-> buf_last_q[0])
    else $error("error result not marked as end of stream");

  a_stream_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> (phase_q == 2'd0) && (pad_q == 2'd0) && !pend_vld_q)
    else $error("stream state not cleared after the last item");

endmodule

`default_nettype wire

### verif/b64sc_checker.sv
// Result checker for the base64 stream codec: watches the config, input and result channels.
// It predicts every result from the accepted transactions and compares it with what arrives.
// Depends on b64sc_pkg for the direction, error and character codes.
module b64sc_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_data_i,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,
  input  logic       m_tlast_i,
  input  logic [1:0] m_tuser_i,
  output int         pending_o,
  output int         fail_count_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic [1:0] err;
  } codec_res_t;

  codec_res_t coded_q[$];
  codec_res_t burst[4];
  int         burst_n;

  // Private copy of the codec state.
  logic       dir_q;
  logic [1:0] phase_q;
  logic [5:0] resid_q;
  logic [1:0] pads_q;
  logic [7:0] held_b;
  logic       held_v;

  int fails = 0;
  int checked = 0;

  function automatic logic [7:0] six_to_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (w <= 8'd25) begin
      six_to_char = 8'h41 + w;               // 'A'..'Z'
    end else if (w <= 8'd51) begin
      six_to_char = 8'h61 + (w - 8'd26);     // 'a'..'z'
    end else if (w <= 8'd61) begin
      six_to_char = 8'h30 + (w - 8'd52);     // '0'..'9'
    end else if (w == 8'd62) begin
      six_to_char = 8'h2B;                   // '+'
    end else begin
      six_to_char = 8'h2F;                   // '/'
    end
  endfunction

  function automatic logic [6:0] char_class(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      t = 8'd62;
    end else if (c == 8'h2F) begin
      t = 8'd63;
    end else if (c == b64sc_pkg::PAD_CHAR) begin
      t = {1'b0, b64sc_pkg::CODE_PAD};
    end else begin
      t = {1'b0, b64sc_pkg::CODE_BAD};
    end
    char_class = t[6:0];
  endfunction

  task automatic clear_stream();
    phase_q = 2'd0;
    resid_q = 6'd0;
    pads_q  = 2'd0;
    held_b  = 8'd0;
    held_v  = 1'b0;
  endtask

  task automatic add(input logic [7:0] v, input logic l, input logic [1:0] e);
    burst[burst_n].value = v;
    burst[burst_n].last  = l;
    burst[burst_n].err   = e;
    burst_n++;
  endtask

  // Works out the results of one accepted input transaction and queues them.
  task automatic code_item(input logic [7:0] v, input logic lst);
    logic [6:0] code;
    logic [1:0] ph;
    logic [5:0] r;
    logic       have;
    logic [7:0] byte_v;
    burst_n = 0;
    r = resid_q;
    ph = phase_q;
    if (dir_q == b64sc_pkg::DIR_ENC) begin
      case (ph)
        2'd0: begin
          add(six_to_char(v[7:2]), 1'b0, b64sc_pkg::ERR_NONE);
          resid_q = {v[1:0], 4'b0000};
          phase_q = 2'd1;
          if (lst) begin
            add(six_to_char(resid_q), 1'b0, b64sc_pkg::ERR_NONE);
            add(b64sc_pkg::PAD_CHAR, 1'b0, b64sc_pkg::ERR_NONE);
            add(b64sc_pkg::PAD_CHAR, 1'b0, b64sc_pkg::ERR_NONE);
          end
        end
        2'd1: begin
          add(six_to_char(r | {2'b00, v[7:4]}), 1'b0, b64sc_pkg::ERR_NONE);
          resid_q = {v[3:0], 2'b00};
          phase_q = 2'd2;
          if (lst) begin
            add(six_to_char(resid_q), 1'b0, b64sc_pkg::ERR_NONE);
            add(b64sc_pkg::PAD_CHAR, 1'b0, b64sc_pkg::ERR_NONE);
          end
        end
        default: begin
          add(six_to_char(r | {4'b0000, v[7:6]}), 1'b0, b64sc_pkg::ERR_NONE);
          add(six_to_char(v[5:0]), 1'b0, b64sc_pkg::ERR_NONE);
          resid_q = 6'd0;
          phase_q = 2'd0;
        end
      endcase
      if (lst) begin
        burst[burst_n - 1].last = 1'b1;
        clear_stream();
      end
    end else begin
      code = char_class(v);
      have = 1'b0;
      byte_v = 8'd0;
      if (code == b64sc_pkg::CODE_BAD || (code == b64sc_pkg::CODE_PAD && ph < 2'd2) ||
          (code != b64sc_pkg::CODE_PAD && pads_q != 2'd0)) begin
        // A character error flushes the held byte and aborts the stream.
        if (held_v) add(held_b, 1'b0, b64sc_pkg::ERR_NONE);
        add(8'd0, 1'b1, b64sc_pkg::ERR_CHAR);
        clear_stream();
      end else begin
        if (code == b64sc_pkg::CODE_PAD) begin
          if (pads_q < 2'd2) pads_q = pads_q + 2'd1;
        end else begin
          case (ph)
            2'd0: resid_q = code[5:0];
            2'd1: begin
              byte_v = {r, code[5:4]};
              resid_q = {2'b00, code[3:0]};
              have = 1'b1;
            end
            2'd2: begin
              byte_v = {r[3:0], code[5:2]};
              resid_q = {4'b0000, code[1:0]};
              have = 1'b1;
            end
            default: begin
              byte_v = {r[1:0], code[5:0]};
              resid_q = 6'd0;
              have = 1'b1;
            end
          endcase
        end
        if (have) begin
          if (held_v) add(held_b, 1'b0, b64sc_pkg::ERR_NONE);
          held_b = byte_v;
          held_v = 1'b1;
        end
        phase_q = ph + 2'd1;
        if (lst) begin
          if (phase_q != 2'd0) begin
            if (held_v) add(held_b, 1'b0, b64sc_pkg::ERR_NONE);
            add(8'd0, 1'b1, b64sc_pkg::ERR_LEN);
          end else if (held_v) begin
            add(held_b, 1'b1, b64sc_pkg::ERR_NONE);
          end
          clear_stream();
        end
      end
    end
    for (int i = 0; i < burst_n; i++) coded_q.insert(coded_q.size(), burst[i]);
  endtask

  always @(posedge clk_i) begin : watch
    codec_res_t want;
    if (!rst_ni) begin
      dir_q = b64sc_pkg::DIR_ENC;
      clear_stream();
      coded_q.delete();
    end else begin
      // Results are compared before this edge's input is predicted; a result can
      // never belong to an item accepted at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (coded_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, got value %h last %b err %0d",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          want = coded_q.pop_front();
          checked++;
          if (m_tdata_i !== want.value || m_tlast_i !== want.last ||
              m_tuser_i !== want.err) begin
            fails++;
            $display({"%0t: result mismatch: expected value %h last %b err %0d,",
                      " got value %h last %b err %0d"},
                     $time, want.value, want.last, want.err,
                     m_tdata_i, m_tlast_i, m_tuser_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        dir_q = cfg_data_i;
        clear_stream();
      end
      if (s_tvalid_i && s_tready_i) code_item(s_tdata_i, s_tlast_i);
    end
    pending_o <= coded_q.size();
    fail_count_o <= fails;
    checked_o <= checked;
  end

endmodule

### verif/tb.sv
// Top of the base64 stream codec testbench: clock, reset, stimulus and verdict.
// Instantiates base64_stream_codec and b64sc_checker; uses b64sc_pkg for codes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int ItemsPerBlock = 53;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  int pending;
  int fail_count;
  int checked;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  logic [7:0] stream_q[$];
  string alpha_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  always #5ns clk_i = ~clk_i;

  base64_stream_codec u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  b64sc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Appends one byte or character to the stream being built.
  task automatic queue_char(input logic [7:0] c);
    stream_q.insert(stream_q.size(), c);
  endtask

  // Holds valid high across back-to-back transactions; it only drops for a gap.
  task automatic send_item(input logic [7:0] v, input logic l);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tlast <= l;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_stream(input bit with_last);
    for (int i = 0; i < stream_q.size(); i++) begin
      send_item(stream_q[i], with_last && (i == stream_q.size() - 1));
    end
    stream_q.delete();
  endtask

  task automatic load_text(input string t);
    for (int i = 0; i < t.len(); i++) queue_char(t[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // The register is only written with the codec idle; a few extra cycles cover
  // items that cause no result.
  task automatic write_direction(input logic d);
    drain();
    repeat (8) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic make_enc_stream(output bit with_last);
    int len;
    len = $urandom_range(7, 1);
    for (int i = 0; i < len; i++) queue_char(8'($urandom_range(255)));
    with_last = ($urandom_range(9) != 0);
  endtask

  // Mostly well-formed groups, some of them padded; the rest is corrupted.
  task automatic make_dec_stream(output bit with_last);
    int groups;
    int pads;
    int kind;
    groups = $urandom_range(3, 1);
    for (int g = 0; g < groups; g++) begin
      pads = 0;
      if (g == groups - 1 && $urandom_range(2) == 0) pads = $urandom_range(2, 1);
      for (int k = 0; k < 4 - pads; k++) queue_char(alpha_set[$urandom_range(63)]);
      for (int k = 0; k < pads; k++) queue_char(b64sc_pkg::PAD_CHAR);
    end
    with_last = 1'b1;
    kind = $urandom_range(9);
    case (kind)
      0: stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom_range(255));
      1: stream_q[$urandom_range(stream_q.size() - 1)] = b64sc_pkg::PAD_CHAR;
      2: begin
        pads = $urandom_range(3, 1);
        for (int k = 0; k < pads; k++) begin
          if (stream_q.size() > 1) void'(stream_q.pop_back());
        end
      end
      3: with_last = 1'b0;
      default: ;
    endcase
  endtask

  task automatic random_block(input logic d);
    int target;
    bit paused;
    bit with_last;
    target = items_sent + ItemsPerBlock;
    paused = 1'b0;
    write_direction(d);
    while (items_sent < target) begin
      if (d == b64sc_pkg::DIR_ENC) make_enc_stream(with_last);
      else make_dec_stream(with_last);
      send_stream(with_last);
      if (!paused && items_sent >= target - ItemsPerBlock / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 34;
    sink_stall_pct = 56;

    // Encode: one, two and three byte groups, all-zero and all-one bytes.
    write_direction(b64sc_pkg::DIR_ENC);
    queue_char(8'h00);
    send_stream(1'b1);
    queue_char(8'hFF);
    queue_char(8'h00);
    send_stream(1'b1);
    repeat (3) queue_char(8'hFF);
    send_stream(1'b1);

    // Decode: full group, padded group with leftover bits, short stream,
    // misplaced pads, a character after a pad, a bad character, a lone character.
    write_direction(b64sc_pkg::DIR_DEC);
    load_text("////");
    send_stream(1'b1);
    load_text("AB==");
    send_stream(1'b1);
    load_text("QUJ");
    send_stream(1'b1);
    load_text("A=");
    send_stream(1'b0);
    load_text("AA=A");
    send_stream(1'b0);
    queue_char(8'hFF);
    send_stream(1'b0);
    load_text("A");
    send_stream(1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_idle_pct = 34; sink_stall_pct = 56; end
        1: begin src_idle_pct = 56; sink_stall_pct = 34; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      random_block(b64sc_pkg::DIR_ENC);
      random_block(b64sc_pkg::DIR_DEC);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Summary: %0d input items and %0d results checked, encode and decode,", items_sent,
             checked);
    $display("with padding, length and character errors under three flow-control patterns.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/b64sc_pkg.sv
rtl/core/base64_stream_codec.sv
verif/b64sc_checker.sv
verif/tb.sv
